// File: src/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared types, constants and the header-byte function of the message packet framer.
// ----------------------------------------------------------------------------
package mpf_pkg;

   localparam int MAX_PACKET_BYTES = 64;
   localparam int MIN_PACKET_BYTES = 10;
   localparam int HEADER_BYTES     = 9;
   localparam int SIZE_WIDTH       = 7;
   localparam int STEP_WIDTH       = $clog2(HEADER_BYTES);
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_WIDTH       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_START = 8'h3F;
   localparam logic [7:0] CHAR_HASH  = 8'h23;

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_PAYLOAD = 2'd1;
   localparam logic [1:0] CMD_END     = 2'd2;

   typedef enum logic [1:0] {
      JOB_HEADER = 2'd0,
      JOB_DATA   = 2'd1,
      JOB_PAD    = 2'd2
   } job_type;

   typedef struct packed {
      job_type     kind;
      logic [15:0] msg_id;
      logic [31:0] payload_len;
      logic [7:0]  data_byte;
   } job_entry_type;

   function automatic logic [7:0] hdr_byte(input logic [STEP_WIDTH-1:0] step,
                                           input logic [15:0] id,
                                           input logic [31:0] size);
      logic [7:0] b;
      case (step)
         4'd0: b = CHAR_START;
         4'd1: b = CHAR_HASH;
         4'd2: b = CHAR_HASH;
         4'd3: b = id[15:8];
         4'd4: b = id[7:0];
         4'd5: b = size[31:24];
         4'd6: b = size[23:16];
         4'd7: b = size[15:8];
         4'd8: b = size[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: src/mpf_front.sv
// ----------------------------------------------------------------------------
// mpf_front
// Accepts input items, tracks whether a message is open and turns each
// accepted item into a job for the back end, or drops it.
// ----------------------------------------------------------------------------
module mpf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  logic [15:0]           req_msg_id,
   input  logic [31:0]           req_payload_len,
   input  logic [7:0]            req_data_byte,
   input  logic                  q_full,
   output logic                  push,
   output mpf_pkg::job_entry_type push_entry
);
   import mpf_pkg::*;

   logic in_message_ff, in_message_in;
   logic accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      push          = 1'b0;
      in_message_in = in_message_ff;
      push_entry.kind        = JOB_DATA;
      push_entry.msg_id      = req_msg_id;
      push_entry.payload_len = req_payload_len;
      push_entry.data_byte   = req_data_byte;
      if (accept) begin
         case (req_cmd)
            CMD_START: begin
               if (!in_message_ff) begin
                  push            = 1'b1;
                  push_entry.kind = JOB_HEADER;
                  in_message_in   = 1'b1;
               end
            end
            CMD_PAYLOAD: begin
               if (in_message_ff) begin
                  push            = 1'b1;
                  push_entry.kind = JOB_DATA;
               end
            end
            CMD_END: begin
               if (in_message_ff) begin
                  push            = 1'b1;
                  push_entry.kind = JOB_PAD;
                  in_message_in   = 1'b0;
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
      end else begin
         in_message_ff <= in_message_in;
      end
   end

endmodule

// File: src/mpf_queue.sv
// ----------------------------------------------------------------------------
// mpf_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mpf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mpf_pkg::job_entry_type push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output mpf_pkg::job_entry_type head_entry
);
   import mpf_pkg::*;

   job_entry_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full       = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/mpf_back.sv
// ----------------------------------------------------------------------------
// mpf_back
// Byte sequencer: works through queued jobs one output byte per cycle while
// rsp_stall is low, keeps the packet fill position and holds the output register.
// ----------------------------------------------------------------------------
module mpf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mpf_pkg::SIZE_WIDTH-1:0] size,
   input  logic                          head_valid,
   input  mpf_pkg::job_entry_type        head_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_packet_end,
   output logic                          rsp_run_last
);
   import mpf_pkg::*;

   logic [SIZE_WIDTH-1:0] fill_ff, fill_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  end_ff, end_in;
   logic                  last_ff, last_in;
   logic                  out_adv;
   logic                  emit;
   logic                  full_pkt;

   assign out_adv  = !valid_ff || !rsp_stall;
   assign full_pkt = (fill_ff >= size);

   always_comb begin
      pop     = 1'b0;
      emit    = 1'b0;
      byte_in = 8'h00;
      fill_in = fill_ff;
      step_in = step_ff;
      last_in = 1'b0;
      if (head_valid && out_adv) begin
         case (head_entry.kind)
            JOB_HEADER: begin
               emit    = 1'b1;
               byte_in = hdr_byte(step_ff, head_entry.msg_id, head_entry.payload_len);
               fill_in = (step_ff == '0) ? SIZE_WIDTH'(1) : fill_ff + 1'b1;
               if (step_ff == STEP_WIDTH'(HEADER_BYTES - 1)) begin
                  last_in = 1'b1;
                  pop     = 1'b1;
                  step_in = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
            JOB_DATA: begin
               emit = 1'b1;
               if (step_ff == '0 && full_pkt) begin
                  byte_in = CHAR_START;
                  fill_in = SIZE_WIDTH'(1);
                  step_in = STEP_WIDTH'(1);
               end else begin
                  byte_in = head_entry.data_byte;
                  fill_in = fill_ff + 1'b1;
                  last_in = 1'b1;
                  pop     = 1'b1;
                  step_in = '0;
               end
            end
            JOB_PAD: begin
               if (full_pkt) begin
                  pop = 1'b1;
               end else begin
                  emit    = 1'b1;
                  fill_in = fill_ff + 1'b1;
                  if (fill_in == size) begin
                     last_in = 1'b1;
                     pop     = 1'b1;
                  end
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
      end_in   = (fill_in == size);
      valid_in = out_adv ? emit : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && emit) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_packet_end = end_ff;
   assign rsp_run_last   = last_ff;

endmodule

// File: src/message_packet_framer_unit.sv
// ----------------------------------------------------------------------------
// message_packet_framer_unit
// Splits a message into fixed-size packets, emitted one output byte at a time.
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      cmd, msg_id, payload_len, data_byte
//   rsp_     out        valid / stall      out_byte, packet_end, run_last
//   csr_     in         valid / ready      pkt_bytes
//
// the back-end sequencer emits one byte per cycle while rsp_stall is low: a
// payload item gives its data byte (after a start byte if it opens a
// continuation packet), a start the nine header bytes, an end pad bytes up to
// the packet size (none if already full); a two-entry job queue lets the input run ahead
// reset is synchronous: message closed, fill position zero, packet size 64
// req_stall rises when the job queue is full; rsp_stall holds the output
// register and with it the sequencer
// ----------------------------------------------------------------------------
module message_packet_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_msg_id,
   input  logic [31:0] req_payload_len,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_end,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mpf_pkg::SIZE_WIDTH-1:0] csr_pkt_bytes
);
   import mpf_pkg::*;

   logic [SIZE_WIDTH-1:0] pkt_bytes_ff;
   logic [SIZE_WIDTH-1:0] eff_size;
   logic                  q_full, push, pop, head_valid;
   job_entry_type         push_entry, head_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_bytes_ff <= SIZE_WIDTH'(MAX_PACKET_BYTES);
      end else if (csr_valid && csr_ready) begin
         pkt_bytes_ff <= csr_pkt_bytes;
      end
   end

   always_comb begin
      if (pkt_bytes_ff < SIZE_WIDTH'(MIN_PACKET_BYTES)) begin
         eff_size = SIZE_WIDTH'(MIN_PACKET_BYTES);
      end else if (pkt_bytes_ff > SIZE_WIDTH'(MAX_PACKET_BYTES)) begin
         eff_size = SIZE_WIDTH'(MAX_PACKET_BYTES);
      end else begin
         eff_size = pkt_bytes_ff;
      end
   end

   mpf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_msg_id      (req_msg_id),
      .req_payload_len (req_payload_len),
      .req_data_byte   (req_data_byte),
      .q_full          (q_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   mpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mpf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .size           (eff_size),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_packet_end (rsp_packet_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule
